// ===== sv/prup_pkg.sv =====
// prup_pkg: shared types and constants for the pixel replicate upscaler.
// Used by prup_ctrl, prup_line_ram, prup_out_fifo and pixel_replicate_upscaler.
// No dependencies.
package prup_pkg;

	localparam int SCALE_W    = 7;
	localparam int SRCW_W     = 11;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	typedef enum logic [0:0] {
		REQ_PIXEL = 1'b0,
		REQ_DRAIN = 1'b1
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE = 1'b0,
		CFG_WIDTH = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic is_pad;
		logic row_end;
		logic overflow;
	} res_meta_t;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
		logic            is_pad;
		logic            row_end;
		logic            overflow;
	} out_item_t;

endpackage

// ===== sv/prup_line_ram.sv =====
// prup_line_ram: two-row ping-pong line store, one write port and one read port.
// Read data registered. Depends on prup_pkg.
module prup_line_ram
	import prup_pkg::*;
#(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [PIX_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/prup_out_fifo.sv =====
// prup_out_fifo: small result queue that decouples the line store read from
// the output handshake. Depends on prup_pkg.
module prup_out_fifo
	import prup_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  out_item_t          push_item,
	input  logic               pop,
	output out_item_t          head,
	output logic               not_empty,
	output logic [FIFO_CW-1:0] count
);

	out_item_t          entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end else begin
				count_q <= count_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == FIFO_CW'(FIFO_DEPTH)) |-> (!push || pop))
		else $error("result queue overrun");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("result queue underrun");

endmodule

// ===== sv/prup_ctrl.sv =====
// prup_ctrl: configuration registers and the write/read sequencing of the
// line store (columns, banks, repeat and pad counters). Depends on prup_pkg.
module prup_ctrl
	import prup_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int AW        = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  acc,
	input  logic                  req_type,
	input  logic [PIX_W-1:0]      pix_in,
	output logic                  ram_we,
	output logic [AW-1:0]         ram_waddr,
	output logic [PIX_W-1:0]      ram_wdata,
	output logic                  ram_re,
	output logic [AW-1:0]         ram_raddr,
	output logic                  res_valid,
	output res_meta_t             res_meta
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [SCALE_W-1:0] scale_q;
	logic [SRCW_W-1:0]  srcw_q;
	logic [CW-1:0]      wcol_q, wcol_d;
	logic               wbank_q, wbank_d;
	logic [1:0]         pend_q, pend_d;
	logic               rbank_q, rbank_d;
	logic [CW-1:0]      rcol_q, rcol_d;
	logic [SCALE_W-1:0] prc_q, prc_d;
	logic [SCALE_W-1:0] rrc_q, rrc_d;
	logic [1:0]         pad_q, pad_d;
	logic               ovf_q, ovf_d;

	logic [WW-1:0]      w_eff;
	logic [WW:0]        wcol_inc, rcol_inc;
	logic [SCALE_W:0]   prc_inc, rrc_inc;
	logic [1:0]         pads;
	logic               do_finish, do_drop;

	function automatic logic [AW-1:0] line_addr(input logic bank, input logic [CW-1:0] col);
		logic [AW-1:0] base;
		base = bank ? AW'(MAX_WIDTH) : '0;
		return base + AW'(col);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(1);
			srcw_q  <= SRCW_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				CFG_WIDTH: srcw_q  <= cfg_data[SRCW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (srcw_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(srcw_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(srcw_q);
		end
	end

	assign wcol_inc = (WW + 1)'(wcol_q) + 1'b1;
	assign rcol_inc = (WW + 1)'(rcol_q) + 1'b1;
	assign prc_inc  = {1'b0, prc_q} + 1'b1;
	assign pads     = 2'(w_eff) * scale_q[1:0];

	always_comb begin
		wcol_d    = wcol_q;
		wbank_d   = wbank_q;
		pend_d    = pend_q;
		rbank_d   = rbank_q;
		rcol_d    = rcol_q;
		prc_d     = prc_q;
		rrc_d     = rrc_q;
		pad_d     = pad_q;
		ovf_d     = ovf_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		res_valid = 1'b0;
		res_meta  = '{is_pad: 1'b0, row_end: 1'b0, overflow: ovf_q};
		do_finish = 1'b0;
		do_drop   = 1'b0;

		if (acc) begin
			if (req_kind_t'(req_type) == REQ_PIXEL) begin
				if (pend_q >= 2'd2) begin
					ovf_d = 1'b1;
				end else begin
					ram_we = 1'b1;
					if (wcol_inc >= {1'b0, w_eff}) begin
						wcol_d = '0;
						if (scale_q != '0) begin
							wbank_d = ~wbank_q;
							pend_d  = pend_q + 1'b1;
						end
					end else begin
						wcol_d = wcol_q + 1'b1;
					end
				end
			end else if (pend_q != '0) begin
				if (scale_q == '0) begin
					do_drop = 1'b1;
				end else begin
					res_valid = 1'b1;
					if (pad_q != '0) begin
						res_meta.is_pad = 1'b1;
						pad_d = pad_q - 1'b1;
						if (pad_q == 2'd1) begin
							res_meta.row_end = 1'b1;
							do_finish = 1'b1;
						end
					end else begin
						ram_re = 1'b1;
						prc_d  = prc_inc[SCALE_W-1:0];
						if (prc_inc >= {1'b0, scale_q}) begin
							prc_d = '0;
							if (rcol_inc >= {1'b0, w_eff}) begin
								if (pads == '0) begin
									res_meta.row_end = 1'b1;
									do_finish = 1'b1;
								end else begin
									pad_d = pads;
								end
							end else begin
								rcol_d = rcol_q + 1'b1;
							end
						end
					end
				end
			end
		end

		rrc_inc = {1'b0, rrc_q} + 1'b1;
		if (do_finish) begin
			rcol_d = '0;
			prc_d  = '0;
			rrc_d  = rrc_inc[SCALE_W-1:0];
			if (rrc_inc >= {1'b0, scale_q}) begin
				do_drop = 1'b1;
			end
		end
		if (do_drop) begin
			rcol_d  = '0;
			prc_d   = '0;
			rrc_d   = '0;
			pad_d   = '0;
			rbank_d = ~rbank_q;
			pend_d  = pend_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcol_q  <= '0;
			wbank_q <= 1'b0;
			pend_q  <= '0;
			rbank_q <= 1'b0;
			rcol_q  <= '0;
			prc_q   <= '0;
			rrc_q   <= '0;
			pad_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			wcol_q  <= wcol_d;
			wbank_q <= wbank_d;
			pend_q  <= pend_d;
			rbank_q <= rbank_d;
			rcol_q  <= rcol_d;
			prc_q   <= prc_d;
			rrc_q   <= rrc_d;
			pad_q   <= pad_d;
			ovf_q   <= ovf_d;
		end
	end

	assign ram_waddr = line_addr(wbank_q, wcol_q);
	assign ram_wdata = pix_in;
	assign ram_raddr = line_addr(rbank_q, rcol_q);

	a_pend_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more than two rows pending");

	a_pad_needs_row: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_q != '0) |-> (pend_q != '0))
		else $error("pads owed with no row pending");

	a_banks_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd1) |-> (wbank_q != rbank_q))
		else $error("write bank collides with the row being read");

endmodule

// ===== sv/pixel_replicate_upscaler.sv =====
// pixel_replicate_upscaler: integer nearest-neighbor upscaler for 24-bit rows.
// Instantiates prup_ctrl, prup_line_ram, prup_out_fifo; depends on prup_pkg.
//
//  channel | signals                                         | dir
//  in      | in_valid/in_ready, req_type, blue/green/red_in  | request in
//  out     | out_valid/out_ready, blue/green/red_out, is_pad, | result out
//          | row_end, overflow                                |
//  cfg     | cfg_wr_en, cfg_index, cfg_data                  | register write
//
// One request per cycle while in_ready is high; a drain result passes through the
// registered line store read, then the result queue.
// in_ready drops only when the four-entry result queue plus the read in flight
// would be full; stalls on out hold requests in the queue.
// Reset clears all control state; line store contents are undefined until written.
module pixel_replicate_upscaler
	import prup_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [CH_W-1:0]       blue_in,
	input  logic [CH_W-1:0]       green_in,
	input  logic [CH_W-1:0]       red_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CH_W-1:0]       blue_out,
	output logic [CH_W-1:0]       green_out,
	output logic [CH_W-1:0]       red_out,
	output logic                  is_pad,
	output logic                  row_end,
	output logic                  overflow
);

	localparam int DEPTH = 2 * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);

	logic               acc;
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [PIX_W-1:0]   ram_wdata, ram_rdata;
	logic               res_valid;
	res_meta_t          res_meta;
	logic               valid_s1;
	res_meta_t          meta_s1;
	out_item_t          push_item, head;
	logic               pop;
	logic [FIFO_CW-1:0] fifo_count;
	logic [FIFO_CW-1:0] fill;

	assign fill     = fifo_count + FIFO_CW'(valid_s1);
	assign in_ready = (fill < FIFO_CW'(FIFO_DEPTH));
	assign acc      = in_valid && in_ready;

	prup_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.req_type  (req_type),
		.pix_in    ({red_in, green_in, blue_in}),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.res_valid (res_valid),
		.res_meta  (res_meta)
	);

	prup_line_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			meta_s1 <= res_meta;
		end
	end

	always_comb begin
		push_item.blue     = meta_s1.is_pad ? '0 : ram_rdata[CH_W-1:0];
		push_item.green    = meta_s1.is_pad ? '0 : ram_rdata[2*CH_W-1:CH_W];
		push_item.red      = meta_s1.is_pad ? '0 : ram_rdata[PIX_W-1:2*CH_W];
		push_item.is_pad   = meta_s1.is_pad;
		push_item.row_end  = meta_s1.row_end;
		push_item.overflow = meta_s1.overflow;
	end

	assign pop = out_valid && out_ready;

	prup_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.not_empty (out_valid),
		.count     (fifo_count)
	);

	assign blue_out  = head.blue;
	assign green_out = head.green;
	assign red_out   = head.red;
	assign is_pad    = head.is_pad;
	assign row_end   = head.row_end;
	assign overflow  = head.overflow;

	a_room_for_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (fifo_count < FIFO_CW'(FIFO_DEPTH)))
		else $error("read result arrives with no queue room");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> valid_s1)
		else $error("drain result lost between stages");

endmodule
